// File: src/battery_power_state_supervisor_core_assert.svh
// assertion macros used by the checker file
`ifndef BATTERY_POWER_STATE_SUPERVISOR_CORE_ASSERT_SVH
`define BATTERY_POWER_STATE_SUPERVISOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define BPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define BPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/bps_pkg.sv
package bps_pkg;

    // field widths
    localparam int MV_W     = 13;
    localparam int PCT_W    = 17;
    localparam int FLAGS_W  = 2;
    localparam int BASE_W   = 27;
    localparam int SLEEP_W  = 29;
    localparam int LIFE_W   = 27;
    localparam int CODE_W   = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_FLAGS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_PCT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOLAR_THRESH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY_FULL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SLEEP     = 3'd6;

    // power states
    localparam logic [CODE_W-1:0] ST_NORMAL   = 3'd0;
    localparam logic [CODE_W-1:0] ST_SAVE     = 3'd1;
    localparam logic [CODE_W-1:0] ST_LOW      = 3'd2;
    localparam logic [CODE_W-1:0] ST_CRITICAL = 3'd3;
    localparam logic [CODE_W-1:0] ST_CHARGING = 3'd4;

    // power modes
    localparam logic [CODE_W-1:0] MD_MAX_PERF  = 3'd0;
    localparam logic [CODE_W-1:0] MD_BALANCED  = 3'd1;
    localparam logic [CODE_W-1:0] MD_ECO       = 3'd2;
    localparam logic [CODE_W-1:0] MD_SURVIVAL  = 3'd3;
    localparam logic [CODE_W-1:0] MD_HIBERNATE = 3'd4;

    // charge limits in milli-percent
    localparam logic [PCT_W-1:0] CHARGE_FULL   = 17'd100000;
    localparam logic [PCT_W-1:0] CHARGE_HALF   = 17'd50000;
    localparam logic [PCT_W-1:0] CHARGE_QUART  = 17'd25000;
    localparam logic [PCT_W-1:0] CHARGE_SURV   = 17'd20000;
    localparam logic [PCT_W-1:0] CHARGE_TENTH  = 17'd10000;
    localparam logic [LIFE_W-1:0] LIFE_PER_MPCT = 27'd864;

    // configuration register set
    typedef struct packed {
        logic [FLAGS_W-1:0] control_flags;
        logic [PCT_W-1:0]   duty_threshold_pct;
        logic [PCT_W-1:0]   critical_pct;
        logic [PCT_W-1:0]   low_pct;
        logic [MV_W-1:0]    solar_threshold_mv;
        logic [MV_W-1:0]    battery_full_mv;
        logic [BASE_W-1:0]  base_sleep_ms;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [PCT_W-1:0]   charge_mpct;
        logic               charging;
        logic [CODE_W-1:0]  power_state;
        logic [CODE_W-1:0]  power_mode;
        logic               state_changed;
        logic               mode_changed;
        logic               sleep_request;
        logic [SLEEP_W-1:0] sleep_ms;
        logic [LIFE_W-1:0]  life_ms;
    } t_result;

endpackage

// File: src/bps_in_if.sv
// measurement item channel
interface bps_in_if import bps_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MV_W-1:0] battery_mv;
    logic [MV_W-1:0] solar_mv;

    modport source (output valid, battery_mv, solar_mv, input ready);
    modport sink   (input valid, battery_mv, solar_mv, output ready);
endinterface

// File: src/bps_out_if.sv
// result item channel
interface bps_out_if import bps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PCT_W-1:0]   charge_mpct;
    logic               charging;
    logic [CODE_W-1:0]  power_state;
    logic [CODE_W-1:0]  power_mode;
    logic               state_changed;
    logic               mode_changed;
    logic               sleep_request;
    logic [SLEEP_W-1:0] sleep_ms;
    logic [LIFE_W-1:0]  life_ms;

    modport source (output valid, charge_mpct, charging, power_state, power_mode,
                    state_changed, mode_changed, sleep_request, sleep_ms, life_ms,
                    input ready);
    modport sink   (input valid, charge_mpct, charging, power_state, power_mode,
                    state_changed, mode_changed, sleep_request, sleep_ms, life_ms,
                    output ready);
endinterface

// File: src/bps_cfg_if.sv
// configuration write channel
interface bps_cfg_if import bps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/bps_cfg.sv
module bps_cfg import bps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output logic                  o_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always accepted
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // register decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            case (i_index)
                REG_CONTROL_FLAGS:  n_cfg.control_flags      = i_data[FLAGS_W-1:0];
                REG_DUTY_THRESHOLD: n_cfg.duty_threshold_pct = i_data[PCT_W-1:0];
                REG_CRITICAL_PCT:   n_cfg.critical_pct       = i_data[PCT_W-1:0];
                REG_LOW_PCT:        n_cfg.low_pct            = i_data[PCT_W-1:0];
                REG_SOLAR_THRESH:   n_cfg.solar_threshold_mv = i_data[MV_W-1:0];
                REG_BATTERY_FULL:   n_cfg.battery_full_mv    = i_data[MV_W-1:0];
                REG_BASE_SLEEP:     n_cfg.base_sleep_ms      = i_data[BASE_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.control_flags      <= '0;
            r_cfg.duty_threshold_pct <= 17'd30000;
            r_cfg.critical_pct       <= 17'd10000;
            r_cfg.low_pct            <= 17'd20000;
            r_cfg.solar_threshold_mv <= 13'd4500;
            r_cfg.battery_full_mv    <= 13'd4200;
            r_cfg.base_sleep_ms      <= 27'd300000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: src/bps_curve.sv
module bps_curve import bps_pkg::*; (
    input  logic [MV_W-1:0]  i_battery_mv,
    output logic [PCT_W-1:0] o_charge_mpct
);

    logic [MV_W-1:0] d_3900;
    logic [MV_W-1:0] d_3700;
    logic [MV_W-1:0] d_3400;
    logic [MV_W-1:0] d_3000;

    // offsets into each segment, each below 400 mV where used
    assign d_3900 = i_battery_mv - 13'd3900;
    assign d_3700 = i_battery_mv - 13'd3700;
    assign d_3400 = i_battery_mv - 13'd3400;
    assign d_3000 = i_battery_mv - 13'd3000;

    // li-ion discharge curve: four linear segments from 3000 to 4100 mV, clamped outside
    always_comb begin
        if (i_battery_mv >= 13'd4100) begin
            o_charge_mpct = CHARGE_FULL;
        end else if (i_battery_mv >= 13'd3900) begin
            o_charge_mpct = 17'd80000 + {9'd0, d_3900[7:0]} * 17'd100;
        end else if (i_battery_mv >= 13'd3700) begin
            o_charge_mpct = 17'd40000 + {9'd0, d_3700[7:0]} * 17'd200;
        end else if (i_battery_mv >= 13'd3400) begin
            o_charge_mpct = 17'd10000 + {8'd0, d_3400[8:0]} * 17'd100;
        end else if (i_battery_mv >= 13'd3000) begin
            o_charge_mpct = {8'd0, d_3000[8:0]} * 17'd25;
        end else begin
            o_charge_mpct = '0;
        end
    end

endmodule

// File: src/bps_policy.sv
module bps_policy import bps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [MV_W-1:0]  i_battery_mv,
    input  logic [MV_W-1:0]  i_solar_mv,
    input  logic [PCT_W-1:0] i_charge_mpct,
    input  t_cfg             i_cfg,
    output t_result          o_result
);

    logic [CODE_W-1:0]  r_state;
    logic [CODE_W-1:0]  r_mode;
    logic [CODE_W-1:0]  n_state;
    logic [CODE_W-1:0]  n_mode;
    logic               save_en;
    logic               duty_en;
    logic               charging;
    logic               request;
    logic [2:0]         mult;
    logic [SLEEP_W:0]   sleep_full;
    logic [SLEEP_W-1:0] sleep_sat;

    assign save_en  = i_cfg.control_flags[0];
    assign duty_en  = i_cfg.control_flags[1];
    assign charging = (i_solar_mv >= i_cfg.solar_threshold_mv) &&
                      (i_battery_mv < i_cfg.battery_full_mv);

    // power state by priority
    always_comb begin
        if (charging) begin
            n_state = ST_CHARGING;
        end else if (i_charge_mpct <= i_cfg.critical_pct) begin
            n_state = ST_CRITICAL;
        end else if (i_charge_mpct <= i_cfg.low_pct) begin
            n_state = ST_LOW;
        end else if (save_en && (i_charge_mpct < CHARGE_HALF)) begin
            n_state = ST_SAVE;
        end else begin
            n_state = ST_NORMAL;
        end
    end

    // mode follows the state only with power saving on
    always_comb begin
        n_mode = r_mode;
        if (save_en) begin
            case (n_state)
                ST_CRITICAL: n_mode = MD_HIBERNATE;
                ST_LOW:      n_mode = MD_SURVIVAL;
                ST_SAVE:     n_mode = MD_ECO;
                default:     n_mode = MD_BALANCED;
            endcase
        end
    end

    // deep sleep request
    assign request = save_en && ((n_state == ST_CRITICAL) ||
                     ((n_mode == MD_SURVIVAL) && (i_charge_mpct < CHARGE_SURV)) ||
                     (duty_en && (i_charge_mpct < i_cfg.duty_threshold_pct)));

    // sleep scale by charge band
    always_comb begin
        if (i_charge_mpct < CHARGE_TENTH) begin
            mult = 3'd5;
        end else if (i_charge_mpct < CHARGE_QUART) begin
            mult = 3'd3;
        end else if (i_charge_mpct < CHARGE_HALF) begin
            mult = 3'd2;
        end else begin
            mult = 3'd1;
        end
    end

    assign sleep_full = {3'd0, i_cfg.base_sleep_ms} * {27'd0, mult};
    assign sleep_sat  = sleep_full[SLEEP_W] ? '1 : sleep_full[SLEEP_W-1:0];

    // result item
    always_comb begin
        o_result.charge_mpct   = i_charge_mpct;
        o_result.charging      = charging;
        o_result.power_state   = n_state;
        o_result.power_mode    = n_mode;
        o_result.state_changed = (n_state != r_state);
        o_result.mode_changed  = (n_mode != r_mode);
        o_result.sleep_request = request;
        o_result.sleep_ms      = sleep_sat;
        o_result.life_ms       = {10'd0, i_charge_mpct} * LIFE_PER_MPCT;
    end

    // history updates as each item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NORMAL;
            r_mode  <= MD_BALANCED;
        end else if (i_advance) begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule

// File: src/battery_power_state_supervisor_core.sv
// Battery power-state supervisor. Each input item is one battery and solar
// reading in millivolts; each produces exactly one result item with the charge
// estimate, charging flag, power state and mode, change flags, deep-sleep
// request, recommended sleep time and estimated remaining life. One item is
// accepted every clock cycle while the result side is ready; each item passes
// through the input register and then the result register. While a result
// waits, one more item can enter the input register and then the input
// stalls until the result is taken. The power state and mode history update as
// each item moves from the input register to the result register, which is
// what keeps items in order one per cycle. Configuration writes complete in
// the cycle they are presented and should be issued only while no items are in
// flight.
module battery_power_state_supervisor_core import bps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bps_in_if.sink    i_in,
    bps_out_if.source o_out,
    bps_cfg_if.sink   i_cfg
);

    t_cfg             cfg;
    t_result          result;
    logic             r_s1_valid;
    logic             n_s1_valid;
    logic [MV_W-1:0]  r_battery_mv;
    logic [MV_W-1:0]  r_solar_mv;
    logic [PCT_W-1:0] charge;
    logic             r_out_valid;
    logic             n_out_valid;
    t_result          r_out;
    logic             s1_go;
    logic             in_take;

    // configuration registers
    bps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_cfg   (cfg)
    );

    // flow control between input and result registers
    assign s1_go       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_go;
    assign in_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_go) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_battery_mv <= i_in.battery_mv;
            r_solar_mv   <= i_in.solar_mv;
        end
    end

    // charge curve and decision logic
    bps_curve u_curve (
        .i_battery_mv  (r_battery_mv),
        .o_charge_mpct (charge)
    );

    bps_policy u_policy (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (s1_go),
        .i_battery_mv  (r_battery_mv),
        .i_solar_mv    (r_solar_mv),
        .i_charge_mpct (charge),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.charge_mpct   = r_out.charge_mpct;
    assign o_out.charging      = r_out.charging;
    assign o_out.power_state   = r_out.power_state;
    assign o_out.power_mode    = r_out.power_mode;
    assign o_out.state_changed = r_out.state_changed;
    assign o_out.mode_changed  = r_out.mode_changed;
    assign o_out.sleep_request = r_out.sleep_request;
    assign o_out.sleep_ms      = r_out.sleep_ms;
    assign o_out.life_ms       = r_out.life_ms;

endmodule

// File: src/bps_checker.sv
`include "battery_power_state_supervisor_core_assert.svh"

module bps_checker import bps_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [PCT_W-1:0]  i_charge_mpct,
    input logic              i_charging,
    input logic [CODE_W-1:0] i_power_state,
    input logic              i_sleep_request,
    input logic [LIFE_W-1:0] i_life_ms
);

    // a stalled result item stays put
    `BPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_charge_mpct) && $stable(i_power_state))

    // charge estimate never exceeds full
    `BPS_ASSERT_NOW(a_charge_range, i_clk, i_rst_n, i_out_valid, i_charge_mpct <= CHARGE_FULL)

    // charging always wins the state priority
    `BPS_ASSERT_NOW(a_charging_state, i_clk, i_rst_n, i_out_valid && i_charging, i_power_state == ST_CHARGING)

    // remaining life tracks the charge estimate
    `BPS_ASSERT_NOW(a_life_scale, i_clk, i_rst_n, i_out_valid, i_life_ms == LIFE_W'({10'd0, i_charge_mpct} * LIFE_PER_MPCT))

    // a full charge in the charging state has no sleep request unless the charging flag is set
    `BPS_ASSERT_NOW(a_full_no_request, i_clk, i_rst_n, i_out_valid && (i_charge_mpct == CHARGE_FULL) && (i_power_state == ST_CHARGING), !i_sleep_request || i_charging)

endmodule

bind battery_power_state_supervisor_core bps_checker u_bps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_charge_mpct   (o_out.charge_mpct),
    .i_charging      (o_out.charging),
    .i_power_state   (o_out.power_state),
    .i_sleep_request (o_out.sleep_request),
    .i_life_ms       (o_out.life_ms)
);
